// ===== design/rvexu_pkg.sv =====
// ----------------------------------------------------------------------------
// rvexu_pkg: shared definitions for the RV32I subset execute unit
// Opcodes, function codes, status codes, memory sizing and the result layout.
// ----------------------------------------------------------------------------
package rvexu_pkg;

   // Data memory sizing.
   localparam int DATA_MEM_BYTES = 16384;
   localparam int MEM_WORDS      = DATA_MEM_BYTES / 4;
   localparam int MEM_AW         = $clog2(MEM_WORDS);

   // Register files.
   localparam int RF_DEPTH = 32;
   localparam int RF_AW    = 5;

   // Load tag value that means no load is outstanding.
   localparam logic [6:0] NO_LOAD_TAG = 7'd64;

   // The one system word that halts the unit.
   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

   // Major opcodes that the unit decodes.
   typedef enum logic [6:0] {
      OP_REG    = 7'h33,
      OP_IMM    = 7'h13,
      OP_BRANCH = 7'h63,
      OP_JAL    = 7'h6F,
      OP_JALR   = 7'h67,
      OP_LOAD   = 7'h03,
      OP_STORE  = 7'h23,
      OP_LUI    = 7'h37,
      OP_FLOAD  = 7'h07,
      OP_FSTORE = 7'h27,
      OP_FP     = 7'h53,
      OP_SYSTEM = 7'h73
   } opcode_type;

   // Function codes.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [6:0] F7_ADD  = 7'h00;
   localparam logic [6:0] F7_SUB  = 7'h20;

   // Status codes reported with every result.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_OPCODE = 2'd1,
      ST_ADDR_RANGE = 2'd2,
      ST_FLOAT_OP   = 2'd3
   } status_type;

   // Result word, declared from the highest bit down so that the packed
   // value is the result channel payload without its padding.
   typedef struct packed {
      status_type  status;
      logic        halted;
      logic        branch_flush;
      logic        load_use_stall;
      logic [31:0] store_data;
      logic [31:0] store_addr;
      logic        store_valid;
      logic [31:0] reg_write_data;
      logic [5:0]  reg_write_tag;
      logic        reg_write_valid;
      logic [31:0] next_pc;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);
   localparam int RSP_BITS    = ((RESULT_BITS + 7) / 8) * 8;

endpackage

// ===== design/rv32i_subset_execute_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit: executes one RV32I subset instruction per word
// Holds the PC, integer and float register files and a word data RAM, and
// reports next PC, register write, store and hazard flags for each word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  req_*     in         tdata[31:0] instr_word
//  rsp_*     out        tdata[140:0] result fields (see port comment), 3 pad
//
//  Each instruction first reads the register files (synchronous memories),
//  then executes and accesses the data RAM. Loads write the register file
//  when they retire, overlapped with the register read of the next word
//  (a bypass covers that case). After reset a clearing pass writes every
//  data RAM word and the register files; no word is taken then.
//  The result sits in an output register; a stalled rsp_tready holds
//  one finished word there and one more in the retire stage.
//
module rv32i_subset_execute_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Instruction words.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // [31:0] instr_word
   // Results.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: next_pc(32), reg_write_valid(1), reg_write_tag(6),
   // reg_write_data(32), store_valid(1), store_addr(32), store_data(32),
   // load_use_stall(1), branch_flush(1), halted(1), status(2), zero pad(3).
   output logic [rvexu_pkg::RSP_BITS-1:0]    rsp_tdata
);

   localparam int MW = rvexu_pkg::MEM_WORDS;
   localparam int AW = rvexu_pkg::MEM_AW;

   // Storage.
   logic [31:0] irf [rvexu_pkg::RF_DEPTH];
   logic [31:0] frf [rvexu_pkg::RF_DEPTH];
   logic [31:0] ram [MW];

   // Control and architectural registers.
   logic                   clr_busy_ff;
   logic [AW-1:0]          clr_idx_ff;
   logic                   v1_ff;
   logic                   v2_ff;
   logic                   rsp_tvalid_ff;
   logic [31:0]            pc_ff;
   logic                   halt_ff;
   logic [6:0]             ltag_ff;

   // Pipeline payload registers.
   logic [31:0]            instr_ff;
   logic [31:0]            rs1_rd_ff;
   logic [31:0]            rs2_rd_ff;
   logic [31:0]            frs2_rd_ff;
   logic                   byp1_ff;
   logic                   byp2_ff;
   logic                   bypf_ff;
   logic [31:0]            bypd_ff;
   logic [31:0]            ram_rd_ff;
   rvexu_pkg::result_type  v2_res_ff;
   logic                   v2_load_ff;
   rvexu_pkg::result_type  rsp_ff;

   // Handshake and retire.
   logic accept;
   logic retire;
   logic [31:0] ret_wdata;
   rvexu_pkg::result_type ret_res;
   logic        irf_we;
   logic        frf_we;
   logic [rvexu_pkg::RF_AW-1:0] rf_wa;
   logic [31:0] irf_wd;
   logic [31:0] frf_wd;
   logic        ret_int_we;
   logic        ret_flt_we;

   // Decode of the word in execute.
   rvexu_pkg::opcode_type op;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [6:0]  f7;
   logic [31:0] immi;
   logic [31:0] imms;
   logic [31:0] immb;
   logic [31:0] immj;
   logic [31:0] opa;
   logic [31:0] opb;
   logic [31:0] opf;
   logic [31:0] mem_addr;
   logic        in_range;
   logic [6:0]  tag_rs1;
   logic [6:0]  tag_rs2;
   logic [6:0]  tag_frs1;
   logic [6:0]  tag_frs2;

   // Execute results.
   rvexu_pkg::result_type ex_res;
   logic        ex_load;
   logic        ex_ram_we;
   logic [6:0]  ex_tag;
   logic        ex_halt;
   logic        taken;

   // ------------------------------------------------------------------------
   // Handshake.
   assign retire     = v2_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && !v1_ff && (!v2_ff || retire);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(rvexu_pkg::RSP_BITS - rvexu_pkg::RESULT_BITS)'(0), rsp_ff};

   // ------------------------------------------------------------------------
   // Register file write port: the clearing pass, else the retiring word.
   assign ret_wdata  = v2_load_ff ? ram_rd_ff : v2_res_ff.reg_write_data;
   assign ret_int_we = retire && v2_res_ff.reg_write_valid && !v2_res_ff.reg_write_tag[5];
   assign ret_flt_we = retire && v2_res_ff.reg_write_valid && v2_res_ff.reg_write_tag[5];

   // Retiring word with the load data merged in.
   always_comb begin
      ret_res                = v2_res_ff;
      ret_res.reg_write_data = ret_wdata;
   end

   always_comb begin
      if (clr_busy_ff) begin
         irf_we = clr_idx_ff < AW'(rvexu_pkg::RF_DEPTH);
         frf_we = irf_we;
         rf_wa  = clr_idx_ff[rvexu_pkg::RF_AW-1:0];
         irf_wd = (clr_idx_ff == AW'(2)) ? 32'(MW - 1) : 32'd0;
         frf_wd = 32'd0;
      end else begin
         irf_we = ret_int_we;
         frf_we = ret_flt_we;
         rf_wa  = v2_res_ff.reg_write_tag[rvexu_pkg::RF_AW-1:0];
         irf_wd = ret_wdata;
         frf_wd = ret_wdata;
      end
   end

   // Register files: one write port, reads captured when a word is taken.
   // A write in the same cycle is bypassed to the read.
   always_ff @(posedge clock) begin
      if (irf_we) begin
         irf[rf_wa] <= irf_wd;
      end
      if (frf_we) begin
         frf[rf_wa] <= frf_wd;
      end
      if (accept) begin
         instr_ff   <= req_tdata;
         rs1_rd_ff  <= irf[req_tdata[19:15]];
         rs2_rd_ff  <= irf[req_tdata[24:20]];
         frs2_rd_ff <= frf[req_tdata[24:20]];
         byp1_ff    <= ret_int_we && (rf_wa == req_tdata[19:15]);
         byp2_ff    <= ret_int_we && (rf_wa == req_tdata[24:20]);
         bypf_ff    <= ret_flt_we && (rf_wa == req_tdata[24:20]);
         bypd_ff    <= ret_wdata;
      end
   end

   // ------------------------------------------------------------------------
   // Field decode and operands.
   assign op   = rvexu_pkg::opcode_type'(instr_ff[6:0]);
   assign rd   = instr_ff[11:7];
   assign f3   = instr_ff[14:12];
   assign rs1  = instr_ff[19:15];
   assign rs2  = instr_ff[24:20];
   assign f7   = instr_ff[31:25];
   assign immi = {{20{instr_ff[31]}}, instr_ff[31:20]};
   assign imms = {{20{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
   assign immb = {{19{instr_ff[31]}}, instr_ff[31], instr_ff[7], instr_ff[30:25],
                  instr_ff[11:8], 1'b0};
   assign immj = {{11{instr_ff[31]}}, instr_ff[31], instr_ff[19:12], instr_ff[20],
                  instr_ff[30:21], 1'b0};

   assign opa = byp1_ff ? bypd_ff : rs1_rd_ff;
   assign opb = byp2_ff ? bypd_ff : rs2_rd_ff;
   assign opf = bypf_ff ? bypd_ff : frs2_rd_ff;

   assign mem_addr = ((op == rvexu_pkg::OP_STORE) || (op == rvexu_pkg::OP_FSTORE)) ?
                     (opa + imms) : (opa + immi);
   assign in_range = {2'b00, mem_addr[31:2]} < 32'(MW);

   assign tag_rs1  = {2'b00, rs1};
   assign tag_rs2  = {2'b00, rs2};
   assign tag_frs1 = {2'b01, rs1};
   assign tag_frs2 = {2'b01, rs2};

   // Branch condition.
   always_comb begin
      case (f3)
         rvexu_pkg::F3_BEQ: taken = (opa == opb);
         rvexu_pkg::F3_BNE: taken = (opa != opb);
         rvexu_pkg::F3_BLT: taken = ($signed(opa) < $signed(opb));
         rvexu_pkg::F3_BGE: taken = ($signed(opa) >= $signed(opb));
         default:           taken = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Execute: compute the result and the state updates of the word.
   always_comb begin
      ex_res         = '0;
      ex_res.status  = rvexu_pkg::ST_OK;
      ex_res.next_pc = pc_ff + 32'd4;
      ex_load        = 1'b0;
      ex_ram_we      = 1'b0;
      ex_tag         = rvexu_pkg::NO_LOAD_TAG;
      ex_halt        = 1'b0;

      unique case (op)
         rvexu_pkg::OP_REG: begin
            ex_res.load_use_stall = (tag_rs1 == ltag_ff) || (tag_rs2 == ltag_ff);
            ex_res.reg_write_tag  = {1'b0, rd};
            if (f3 == rvexu_pkg::F3_ADD && f7 == rvexu_pkg::F7_ADD) begin
               ex_res.reg_write_valid = 1'b1;
               ex_res.reg_write_data  = opa + opb;
            end else if (f3 == rvexu_pkg::F3_ADD && f7 == rvexu_pkg::F7_SUB) begin
               ex_res.reg_write_valid = 1'b1;
               ex_res.reg_write_data  = opa - opb;
            end
         end
         rvexu_pkg::OP_IMM: begin
            ex_res.load_use_stall = (tag_rs1 == ltag_ff);
            ex_res.reg_write_tag  = {1'b0, rd};
            if (f3 == rvexu_pkg::F3_ADD) begin
               ex_res.reg_write_valid = 1'b1;
               ex_res.reg_write_data  = opa + immi;
            end else if (f3 == rvexu_pkg::F3_SLL) begin
               ex_res.reg_write_valid = 1'b1;
               ex_res.reg_write_data  = opa << rs2;
            end else if (f3 == rvexu_pkg::F3_SRL) begin
               ex_res.reg_write_valid = 1'b1;
               ex_res.reg_write_data  = opa >> rs2;
            end
         end
         rvexu_pkg::OP_BRANCH: begin
            ex_res.load_use_stall = (tag_rs1 == ltag_ff) || (tag_rs2 == ltag_ff);
            if (taken) begin
               ex_res.branch_flush = 1'b1;
               ex_res.next_pc      = pc_ff + immb;
            end
         end
         rvexu_pkg::OP_JAL: begin
            ex_res.reg_write_valid = 1'b1;
            ex_res.reg_write_tag   = {1'b0, rd};
            ex_res.reg_write_data  = pc_ff + 32'd4;
            ex_res.next_pc         = pc_ff + immj;
         end
         rvexu_pkg::OP_JALR: begin
            ex_res.load_use_stall  = (tag_rs1 == ltag_ff);
            ex_res.reg_write_valid = 1'b1;
            ex_res.reg_write_tag   = {1'b0, rd};
            ex_res.reg_write_data  = pc_ff + 32'd4;
            ex_res.next_pc         = (opa + immi) & ~32'd1;
         end
         rvexu_pkg::OP_LOAD, rvexu_pkg::OP_FLOAD: begin
            ex_res.load_use_stall = (tag_rs1 == ltag_ff);
            ex_tag = (op == rvexu_pkg::OP_LOAD) ? {2'b00, rd} : {2'b01, rd};
            if (f3 == rvexu_pkg::F3_WORD) begin
               if (in_range) begin
                  ex_res.reg_write_valid = 1'b1;
                  ex_res.reg_write_tag   = ex_tag[5:0];
                  ex_load                = 1'b1;
               end else begin
                  ex_res.status = rvexu_pkg::ST_ADDR_RANGE;
               end
            end
         end
         rvexu_pkg::OP_STORE, rvexu_pkg::OP_FSTORE: begin
            ex_res.load_use_stall = (tag_rs1 == ltag_ff) ||
               ((op == rvexu_pkg::OP_STORE) ? (tag_rs2 == ltag_ff) : (tag_frs2 == ltag_ff));
            if (f3 == rvexu_pkg::F3_WORD) begin
               if (in_range) begin
                  ex_res.store_valid = 1'b1;
                  ex_res.store_addr  = mem_addr;
                  ex_res.store_data  = (op == rvexu_pkg::OP_STORE) ? opb : opf;
                  ex_ram_we          = 1'b1;
               end else begin
                  ex_res.status = rvexu_pkg::ST_ADDR_RANGE;
               end
            end
         end
         rvexu_pkg::OP_LUI: begin
            ex_res.reg_write_valid = 1'b1;
            ex_res.reg_write_tag   = {1'b0, rd};
            ex_res.reg_write_data  = {instr_ff[31:12], 12'd0};
         end
         rvexu_pkg::OP_FP: begin
            ex_res.load_use_stall = (tag_frs1 == ltag_ff) || (tag_frs2 == ltag_ff);
            ex_res.status         = rvexu_pkg::ST_FLOAT_OP;
         end
         rvexu_pkg::OP_SYSTEM: begin
            ex_halt = (instr_ff == rvexu_pkg::EBREAK_WORD);
         end
         default: begin
            ex_res.status = rvexu_pkg::ST_BAD_OPCODE;
         end
      endcase

      // Writes to register zero of either file are dropped.
      if (ex_res.reg_write_valid && ex_res.reg_write_tag[4:0] == 5'd0) begin
         ex_res.reg_write_valid = 1'b0;
         ex_load                = 1'b0;
      end
      if (!ex_res.reg_write_valid) begin
         ex_res.reg_write_tag  = 6'd0;
         ex_res.reg_write_data = 32'd0;
      end
      ex_res.halted = ex_halt;

      // A halted unit ignores the word and changes nothing.
      if (halt_ff) begin
         ex_res         = '0;
         ex_res.status  = rvexu_pkg::ST_OK;
         ex_res.next_pc = pc_ff;
         ex_res.halted  = 1'b1;
         ex_load        = 1'b0;
         ex_ram_we      = 1'b0;
         ex_tag         = ltag_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Data RAM: one port, used by the clearing pass, a store or a load.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         ram[clr_idx_ff] <= 32'd0;
      end else if (v1_ff && ex_ram_we) begin
         ram[mem_addr[AW+1:2]] <= ex_res.store_data;
      end else if (v1_ff && ex_load) begin
         ram_rd_ff <= ram[mem_addr[AW+1:2]];
      end
   end

   // ------------------------------------------------------------------------
   // Stage payloads.
   always_ff @(posedge clock) begin
      if (v1_ff) begin
         v2_res_ff  <= ex_res;
         v2_load_ff <= ex_load;
      end
      if (retire) begin
         rsp_ff <= ret_res;
      end
   end

   // Control state, architectural state and the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         pc_ff         <= 32'd0;
         halt_ff       <= 1'b0;
         ltag_ff       <= rvexu_pkg::NO_LOAD_TAG;
      end else begin
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(MW - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (v1_ff) begin
            pc_ff   <= ex_res.next_pc;
            ltag_ff <= ex_tag;
            halt_ff <= halt_ff || ex_halt;
         end
         v1_ff <= accept;
         if (v1_ff) begin
            v2_ff <= 1'b1;
         end else if (retire) begin
            v2_ff <= 1'b0;
         end
         if (retire) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Assertions.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !clr_busy_ff)
      else $error("word accepted during the RAM clearing pass");

   a_execute_advances: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> (v2_ff && !v1_ff))
      else $error("word in execute did not move to the retire stage");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_ff.store_valid) |->
      ({2'b00, rsp_ff.store_addr[31:2]} < 32'(MW)))
      else $error("store reported outside the data RAM");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RV32I subset execute unit
// Streams instruction words into the unit with bursty input and a stalling
// result side, predicts every result word from a private copy of the PC,
// register files and data RAM, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no word moving on either channel before the run is abandoned.
   // Covers the RAM clearing pass after reset and the long result hold-off.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_WORDS   = 1690;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_PRINTED    = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata = '0;   // [31:0] instr_word
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // From bit 0: next_pc, reg_write_valid, reg_write_tag, reg_write_data,
   // store_valid, store_addr, store_data, load_use_stall, branch_flush,
   // halted, status, zero pad.
   logic [rvexu_pkg::RSP_BITS-1:0] rsp_tdata;

   // Shadow copy of the architectural state.
   logic [31:0] core_pc;
   logic [31:0] int_regs [rvexu_pkg::RF_DEPTH];
   logic [31:0] float_regs [rvexu_pkg::RF_DEPTH];
   logic [31:0] data_mem [rvexu_pkg::MEM_WORDS];
   logic [6:0]  load_tag;
   logic        core_halted;

   logic [31:0]           instr_queue [$];
   rvexu_pkg::result_type pending_results [$];
   int          mismatch_count = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;

   // Sender burst and gap bookkeeping.
   int          burst_left;
   int          gap_left;

   // Receiver stall pattern and the one long hold-off.
   int          ready_mode;
   int          mode_cycles;
   int          hold_left;
   bit          hold_done;

   rvexu_pkg::result_type got_result;
   rvexu_pkg::result_type want_result;

   rv32i_subset_execute_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Instruction encoders.
   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [6:0] op);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvexu_pkg::OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvexu_pkg::OP_JAL};
   endfunction

   function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
      return {imm, rd, rvexu_pkg::OP_LUI};
   endfunction

   // Registers mostly come from a small pool so that load tags get hit often.
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 3) == 0)
         return 5'($urandom);
      return 5'($urandom_range(0, 7));
   endfunction

   // Ebreak would freeze the unit, so it is kept out until the very end.
   task automatic queue_word(input logic [31:0] w);
      if (w == rvexu_pkg::EBREAK_WORD)
         w[31] = 1'b1;
      instr_queue.insert(instr_queue.size(), w);
   endtask

   // One instruction of a random kind, with random operands; some kinds take random function codes.
   function automatic logic [31:0] random_instr();
      logic [2:0] f3;
      case ($urandom_range(0, 11))
         0: return enc_r(($urandom_range(0, 1) != 0) ? rvexu_pkg::F7_SUB : rvexu_pkg::F7_ADD,
                         pick_reg(), pick_reg(), rvexu_pkg::F3_ADD, pick_reg(),
                         rvexu_pkg::OP_REG);
         1: return enc_i(12'($urandom), pick_reg(), rvexu_pkg::F3_ADD, pick_reg(),
                         rvexu_pkg::OP_IMM);
         2: return enc_i(12'($urandom), pick_reg(),
                         ($urandom_range(0, 1) != 0) ? rvexu_pkg::F3_SLL : rvexu_pkg::F3_SRL,
                         pick_reg(), rvexu_pkg::OP_IMM);
         3: begin
            case ($urandom_range(0, 4))
               0: f3 = rvexu_pkg::F3_BEQ;
               1: f3 = rvexu_pkg::F3_BNE;
               2: f3 = rvexu_pkg::F3_BLT;
               3: f3 = rvexu_pkg::F3_BGE;
               default: f3 = 3'($urandom);
            endcase
            return enc_b(13'($urandom), pick_reg(), pick_reg(), f3);
         end
         4: return enc_j(21'($urandom), pick_reg());
         5: return enc_i(12'($urandom), pick_reg(), 3'($urandom), pick_reg(),
                         rvexu_pkg::OP_JALR);
         6: return enc_u(20'($urandom), pick_reg());
         7: return enc_r(7'($urandom), pick_reg(), pick_reg(), 3'($urandom), pick_reg(),
                         rvexu_pkg::OP_FP);
         8: return {25'($urandom), rvexu_pkg::OP_SYSTEM};
         9: return enc_i(12'($urandom), pick_reg(), rvexu_pkg::F3_WORD, pick_reg(),
                         ($urandom_range(0, 1) != 0) ? rvexu_pkg::OP_LOAD
                                                     : rvexu_pkg::OP_FLOAD);
         10: return enc_s(12'($urandom), pick_reg(), pick_reg(), rvexu_pkg::F3_WORD,
                          ($urandom_range(0, 1) != 0) ? rvexu_pkg::OP_STORE
                                                      : rvexu_pkg::OP_FSTORE);
         default: return enc_r(7'($urandom), pick_reg(), pick_reg(), 3'($urandom), pick_reg(),
                               ($urandom_range(0, 1) != 0) ? rvexu_pkg::OP_REG
                                                           : rvexu_pkg::OP_IMM);
      endcase
   endfunction

   function automatic logic tag_hit(logic [6:0] src);
      return src == load_tag;
   endfunction

   // Executes one word on the shadow state and returns the result it yields.
   function automatic rvexu_pkg::result_type execute_word(input logic [31:0] w);
      rvexu_pkg::result_type r;
      logic [6:0]  op;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] imm_b;
      logic [31:0] imm_j;
      logic [31:0] addr;
      logic [31:0] npc;
      logic [31:0] wdata;
      logic [5:0]  wtag;
      logic [6:0]  new_tag;
      logic        wv;
      logic        taken;
      logic        stall;

      op = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      rs1 = w[19:15];
      rs2 = w[24:20];
      f7 = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      r = '0;

      // A halted unit only reports the held PC and its halted flag.
      if (core_halted) begin
         r.next_pc = core_pc;
         r.halted = 1'b1;
         return r;
      end

      a = int_regs[rs1];
      b = int_regs[rs2];
      npc = core_pc + 32'd4;
      wv = 1'b0;
      wtag = {1'b0, rd};
      wdata = '0;
      stall = 1'b0;
      taken = 1'b0;
      new_tag = rvexu_pkg::NO_LOAD_TAG;
      r.status = rvexu_pkg::ST_OK;

      case (op)
         rvexu_pkg::OP_REG: begin
            stall = tag_hit({2'b00, rs1}) || tag_hit({2'b00, rs2});
            if (f3 == rvexu_pkg::F3_ADD && f7 == rvexu_pkg::F7_ADD) begin
               wv = 1'b1;
               wdata = a + b;
            end else if (f3 == rvexu_pkg::F3_ADD && f7 == rvexu_pkg::F7_SUB) begin
               wv = 1'b1;
               wdata = a - b;
            end
         end
         rvexu_pkg::OP_IMM: begin
            stall = tag_hit({2'b00, rs1});
            if (f3 == rvexu_pkg::F3_ADD) begin
               wv = 1'b1;
               wdata = a + imm_i;
            end else if (f3 == rvexu_pkg::F3_SLL) begin
               wv = 1'b1;
               wdata = a << imm_i[4:0];
            end else if (f3 == rvexu_pkg::F3_SRL) begin
               wv = 1'b1;
               wdata = a >> imm_i[4:0];
            end
         end
         rvexu_pkg::OP_BRANCH: begin
            stall = tag_hit({2'b00, rs1}) || tag_hit({2'b00, rs2});
            case (f3)
               rvexu_pkg::F3_BEQ: taken = (a == b);
               rvexu_pkg::F3_BNE: taken = (a != b);
               rvexu_pkg::F3_BLT: taken = ($signed(a) < $signed(b));
               rvexu_pkg::F3_BGE: taken = ($signed(a) >= $signed(b));
               default: taken = 1'b0;
            endcase
            if (taken)
               npc = core_pc + imm_b;
            r.branch_flush = taken;
         end
         rvexu_pkg::OP_JAL: begin
            wv = 1'b1;
            wdata = core_pc + 32'd4;
            npc = core_pc + imm_j;
         end
         rvexu_pkg::OP_JALR: begin
            stall = tag_hit({2'b00, rs1});
            npc = (a + imm_i) & ~32'd1;
            wv = 1'b1;
            wdata = core_pc + 32'd4;
         end
         rvexu_pkg::OP_LOAD, rvexu_pkg::OP_FLOAD: begin
            stall = tag_hit({2'b00, rs1});
            new_tag = (op == rvexu_pkg::OP_LOAD) ? {2'b00, rd} : {2'b01, rd};
            if (f3 == rvexu_pkg::F3_WORD) begin
               addr = a + imm_i;
               if (addr[31:2] < 30'(rvexu_pkg::MEM_WORDS)) begin
                  wv = 1'b1;
                  wtag = new_tag[5:0];
                  wdata = data_mem[addr[rvexu_pkg::MEM_AW+1:2]];
               end else begin
                  r.status = rvexu_pkg::ST_ADDR_RANGE;
               end
            end
         end
         rvexu_pkg::OP_STORE, rvexu_pkg::OP_FSTORE: begin
            if (op == rvexu_pkg::OP_STORE)
               stall = tag_hit({2'b00, rs1}) || tag_hit({2'b00, rs2});
            else
               stall = tag_hit({2'b00, rs1}) || tag_hit({2'b01, rs2});
            if (f3 == rvexu_pkg::F3_WORD) begin
               addr = a + imm_s;
               if (addr[31:2] < 30'(rvexu_pkg::MEM_WORDS)) begin
                  r.store_valid = 1'b1;
                  r.store_addr = addr;
                  r.store_data = (op == rvexu_pkg::OP_STORE) ? b : float_regs[rs2];
                  data_mem[addr[rvexu_pkg::MEM_AW+1:2]] = r.store_data;
               end else begin
                  r.status = rvexu_pkg::ST_ADDR_RANGE;
               end
            end
         end
         rvexu_pkg::OP_LUI: begin
            wv = 1'b1;
            wdata = {w[31:12], 12'h000};
         end
         rvexu_pkg::OP_FP: begin
            stall = tag_hit({2'b01, rs1}) || tag_hit({2'b01, rs2});
            r.status = rvexu_pkg::ST_FLOAT_OP;
         end
         rvexu_pkg::OP_SYSTEM: begin
            if (w == rvexu_pkg::EBREAK_WORD)
               core_halted = 1'b1;
         end
         default: r.status = rvexu_pkg::ST_BAD_OPCODE;
      endcase

      // Register zero of either file never takes a write.
      if (wv && wtag[4:0] == 5'd0)
         wv = 1'b0;
      if (wv) begin
         if (wtag[5])
            float_regs[wtag[4:0]] = wdata;
         else
            int_regs[wtag[4:0]] = wdata;
         r.reg_write_valid = 1'b1;
         r.reg_write_tag = wtag;
         r.reg_write_data = wdata;
      end

      core_pc = npc;
      load_tag = new_tag;
      r.next_pc = npc;
      r.load_use_stall = stall;
      r.halted = core_halted;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] result %0d: %s", $realtime, results_seen, what);
   endtask

   // Driver: offers queued words in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 8;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            pending_results.insert(pending_results.size(), execute_word(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (instr_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= instr_queue.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                           : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that changes mode now and then, plus one long
   // hold-off so that the unit fills up and pushes back on its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_mode = 0;
         mode_cycles = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_cycles == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_cycles = $urandom_range(32, 256);
         end
         mode_cycles--;
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // Monitor: every accepted result word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result word with no instruction pending");
         end else begin
            want_result = pending_results.pop_front();
            got_result = rsp_tdata[rvexu_pkg::RESULT_BITS-1:0];
            if (got_result.next_pc !== want_result.next_pc)
               report_mismatch($sformatf("next_pc %h, predicted %h",
                                         got_result.next_pc, want_result.next_pc));
            if (got_result.reg_write_valid !== want_result.reg_write_valid)
               report_mismatch($sformatf("reg_write_valid %b, predicted %b",
                                         got_result.reg_write_valid,
                                         want_result.reg_write_valid));
            if (got_result.reg_write_tag !== want_result.reg_write_tag)
               report_mismatch($sformatf("reg_write_tag %0d, predicted %0d",
                                         got_result.reg_write_tag, want_result.reg_write_tag));
            if (got_result.reg_write_data !== want_result.reg_write_data)
               report_mismatch($sformatf("reg_write_data %h, predicted %h",
                                         got_result.reg_write_data,
                                         want_result.reg_write_data));
            if (got_result.store_valid !== want_result.store_valid)
               report_mismatch($sformatf("store_valid %b, predicted %b",
                                         got_result.store_valid, want_result.store_valid));
            if (got_result.store_addr !== want_result.store_addr)
               report_mismatch($sformatf("store_addr %h, predicted %h",
                                         got_result.store_addr, want_result.store_addr));
            if (got_result.store_data !== want_result.store_data)
               report_mismatch($sformatf("store_data %h, predicted %h",
                                         got_result.store_data, want_result.store_data));
            if (got_result.load_use_stall !== want_result.load_use_stall)
               report_mismatch($sformatf("load_use_stall %b, predicted %b",
                                         got_result.load_use_stall,
                                         want_result.load_use_stall));
            if (got_result.branch_flush !== want_result.branch_flush)
               report_mismatch($sformatf("branch_flush %b, predicted %b",
                                         got_result.branch_flush, want_result.branch_flush));
            if (got_result.halted !== want_result.halted)
               report_mismatch($sformatf("halted %b, predicted %b",
                                         got_result.halted, want_result.halted));
            if (got_result.status !== want_result.status)
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         got_result.status, want_result.status));
         end
      end
   end

   // Watchdog: ends the run when no word moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [4:0]  base;
      logic [11:0] offset;

      // Shadow state after reset.
      core_pc = '0;
      load_tag = rvexu_pkg::NO_LOAD_TAG;
      core_halted = 1'b0;
      for (int i = 0; i < rvexu_pkg::RF_DEPTH; i++) begin
         int_regs[i] = '0;
         float_regs[i] = '0;
      end
      int_regs[2] = 32'(rvexu_pkg::MEM_WORDS - 1);
      for (int i = 0; i < rvexu_pkg::MEM_WORDS; i++)
         data_mem[i] = '0;

      // Directed words: top of data RAM, just past it, load-use hazards on
      // both register files, shift amounts with high immediate bits, extreme
      // branch and jump offsets, dropped writes to register zero, unlisted
      // function codes, float arithmetic and unknown opcodes.
      queue_word(enc_u(20'h00004, 5'd5));                          // x5 = 0x4000
      queue_word(enc_i(12'hFFC, 5'd5, rvexu_pkg::F3_ADD, 5'd5, rvexu_pkg::OP_IMM));
      queue_word(enc_s(12'h000, 5'd2, 5'd5, rvexu_pkg::F3_WORD,    // last RAM word
                       rvexu_pkg::OP_STORE));
      queue_word(enc_i(12'h000, 5'd5, rvexu_pkg::F3_WORD, 5'd6, rvexu_pkg::OP_LOAD));
      queue_word(enc_r(rvexu_pkg::F7_ADD, 5'd6, 5'd6, rvexu_pkg::F3_ADD, 5'd7,
                       rvexu_pkg::OP_REG));                        // uses the load
      queue_word(enc_s(12'h004, 5'd7, 5'd5, rvexu_pkg::F3_WORD,    // one past the end
                       rvexu_pkg::OP_STORE));
      queue_word(enc_i(12'h000, 5'd5, rvexu_pkg::F3_WORD, 5'd3, rvexu_pkg::OP_FLOAD));
      queue_word(enc_s(12'hFF8, 5'd3, 5'd5, rvexu_pkg::F3_WORD,    // float data hazard
                       rvexu_pkg::OP_FSTORE));
      queue_word(enc_i(12'hFFC, 5'd0, rvexu_pkg::F3_WORD, 5'd9,    // wraps out of range
                       rvexu_pkg::OP_LOAD));
      queue_word(enc_i(12'h000, 5'd0, rvexu_pkg::F3_ADD, 5'd10,    // unlisted width
                       rvexu_pkg::OP_LOAD));
      queue_word(enc_r(rvexu_pkg::F7_SUB, 5'd5, 5'd0, rvexu_pkg::F3_ADD, 5'd10,
                       rvexu_pkg::OP_REG));
      queue_word(enc_i(12'h41F, 5'd10, rvexu_pkg::F3_SLL, 5'd11, rvexu_pkg::OP_IMM));
      queue_word(enc_i(12'h43F, 5'd10, rvexu_pkg::F3_SRL, 5'd12, rvexu_pkg::OP_IMM));
      queue_word(enc_i(12'h7FF, 5'd0, rvexu_pkg::F3_ADD, 5'd13, rvexu_pkg::OP_IMM));
      queue_word(enc_i(12'h800, 5'd0, rvexu_pkg::F3_ADD, 5'd14, rvexu_pkg::OP_IMM));
      queue_word(enc_b(13'h1000, 5'd0, 5'd0, rvexu_pkg::F3_BEQ));
      queue_word(enc_b(13'h0FFE, 5'd14, 5'd13, rvexu_pkg::F3_BNE));
      queue_word(enc_b(13'h0008, 5'd13, 5'd14, rvexu_pkg::F3_BLT));
      queue_word(enc_b(13'h0008, 5'd13, 5'd14, rvexu_pkg::F3_BGE));
      queue_word(enc_b(13'h0008, 5'd0, 5'd0, 3'd2));               // never taken
      queue_word(enc_j(21'h100000, 5'd1));
      queue_word(enc_i(12'hFFF, 5'd13, 3'd0, 5'd0, rvexu_pkg::OP_JALR));
      queue_word(enc_r(7'h01, 5'd13, 5'd13, rvexu_pkg::F3_ADD, 5'd15, rvexu_pkg::OP_REG));
      queue_word(enc_i(12'h000, 5'd0, rvexu_pkg::F3_WORD, 5'd0,    // f0 stays zero
                       rvexu_pkg::OP_FLOAD));
      queue_word(enc_r(7'h00, 5'd0, 5'd4, 3'd0, 5'd1, rvexu_pkg::OP_FP));
      queue_word(32'hFFFF_FFFF);
      queue_word(32'h0000_0000);
      queue_word(32'h0000_0073);

      // Random part: memory sequences around a freshly built base address,
      // single instructions of every kind, and some raw noise.
      while (instr_queue.size() < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               base = 5'($urandom_range(1, 31));
               queue_word(enc_u(20'($urandom_range(0, 4)), base));
               queue_word(enc_i(12'($urandom), base, rvexu_pkg::F3_ADD, base,
                                rvexu_pkg::OP_IMM));
               repeat ($urandom_range(1, 5)) begin
                  case ($urandom_range(0, 4))
                     0: offset = 12'h000;
                     1: offset = 12'h004;
                     2: offset = 12'hFFC;
                     3: offset = 12'h008;
                     default: offset = 12'($urandom);
                  endcase
                  case ($urandom_range(0, 5))
                     0: queue_word(enc_i(offset, base, rvexu_pkg::F3_WORD, pick_reg(),
                                         rvexu_pkg::OP_LOAD));
                     1: queue_word(enc_s(offset, pick_reg(), base, rvexu_pkg::F3_WORD,
                                         rvexu_pkg::OP_STORE));
                     2: queue_word(enc_i(offset, base, rvexu_pkg::F3_WORD, pick_reg(),
                                         rvexu_pkg::OP_FLOAD));
                     3: queue_word(enc_s(offset, pick_reg(), base, rvexu_pkg::F3_WORD,
                                         rvexu_pkg::OP_FSTORE));
                     default: queue_word(random_instr());
                  endcase
               end
            end
            7, 8: queue_word($urandom);
            9: queue_word({25'($urandom), ($urandom_range(0, 1) != 0) ? rvexu_pkg::OP_LOAD
                                                                      : rvexu_pkg::OP_STORE});
            default: queue_word(random_instr());
         endcase
      end

      // Halt last, then a few words that the halted unit must ignore.
      instr_queue.insert(instr_queue.size(), rvexu_pkg::EBREAK_WORD);
      repeat (9)
         queue_word(random_instr());

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (instr_queue.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
design/rvexu_pkg.sv
design/rv32i_subset_execute_unit.sv
verif/tb.sv
